// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold
`define DHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen
`define DHT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/dht_pkg.sv =====
package dht_pkg;

    localparam int SLOTS_DEFAULT    = 1024;
    localparam int KEY_BITS_DEFAULT = 32;

    localparam int HASH_W    = 32;
    localparam int KEY_W     = 32;
    localparam int SLOT_W    = 10;
    localparam int TOTAL_W   = 11;
    localparam int CFG_W     = 11;
    localparam int CAP_CFG_W = 11;
    localparam int LIMIT_W   = 7;
    localparam int REG_IDX_W = 1;
    localparam int DIGIT_W   = 4;
    localparam int DIV_STEPS = HASH_W / DIGIT_W;
    localparam int PERCENT   = 100;

    localparam logic [CAP_CFG_W-1:0] CAP_RESET   = 11'd1024;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 7'd66;

    localparam logic [REG_IDX_W-1:0] REG_CAPACITY   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_LOAD_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] primary_hash;
        logic [HASH_W-1:0] step_hash;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [TOTAL_W-1:0] element_total;
    } rsp_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic div_step;
        logic early_result;
        logic probe_first;
        logic probe_next;
        logic commit;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_last;
        logic early_end;
        logic probe_end;
        logic out_free;
    } ctl_sts_t;

endpackage

// ===== rtl/double_hash_table_engine.sv =====
// one item at a time: req_ready is high only in idle, so a new word is taken only once
//   the last one's result is registered onto rsp; the hash reduction by capacity runs
//   at 4 bits per cycle and the probe loop, of 1 to capacity probes, does one slot ram read per cycle
// inserts refused by load and unused commands skip probing
// reset: rst_n asynchronous, active low; a clearing pass then wipes every slot of
//   the slot ram in turn, req_ready stays low meanwhile, cfg writes are taken throughout
module double_hash_table_engine #(
    parameter int SLOTS    = dht_pkg::SLOTS_DEFAULT,
    parameter int KEY_BITS = dht_pkg::KEY_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  dht_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output dht_pkg::rsp_t                 rsp,
    input  logic                          cfg_we,
    input  logic [dht_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [dht_pkg::CFG_W-1:0]     cfg_data
);

    import dht_pkg::*;

    ctl_cmd_t ctl;
    ctl_sts_t sts;

    dht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    dht_datapath #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule

// ===== rtl/dht_ram.sv =====
module dht_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dht_ctrl.sv =====
module dht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dht_pkg::ctl_sts_t sts,
    output dht_pkg::ctl_cmd_t ctl
);

    import dht_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_CHECK = 6'b001000,
        S_PROBE = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.early_end)
                begin
                    ctl.early_result = 1'b1;
                    state_next       = S_EMIT;
                end
                else
                begin
                    ctl.probe_first = 1'b1;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.probe_end)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    ctl.probe_next = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/dht_datapath.sv =====
module dht_datapath #(
    parameter int SLOTS    = dht_pkg::SLOTS_DEFAULT,
    parameter int KEY_BITS = dht_pkg::KEY_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dht_pkg::ctl_cmd_t               ctl,
    output dht_pkg::ctl_sts_t               sts,
    input  logic                            cfg_we,
    input  logic [dht_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [dht_pkg::CFG_W-1:0]       cfg_data,
    input  dht_pkg::req_t                   req,
    output dht_pkg::rsp_t                   rsp,
    output logic                            rsp_valid,
    input  logic                            rsp_ready
);

    import dht_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CAP_W  = $clog2(SLOTS + 1);
    localparam int PROD_W = CAP_W + LIMIT_W;
    localparam int CNT_W  = $clog2(DIV_STEPS);
    localparam int RAM_W  = KEY_BITS + 1;

    // configuration
    logic [CAP_CFG_W-1:0] cap_cfg_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [CAP_W-1:0]     cap_eff;

    // control state
    logic [IDX_W-1:0] clr_reg;
    logic [CAP_W-1:0] count_reg;
    logic [CAP_W-1:0] count_next;
    logic             rsp_valid_reg;

    // item and hash reduction
    logic [1:0]          cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [HASH_W-1:0]   h_sh_reg;
    logic [HASH_W-1:0]   s_sh_reg;
    logic [CAP_W-1:0]    rem_h_reg;
    logic [CAP_W-1:0]    rem_s_reg;
    logic [CAP_W-1:0]    rem_h_next;
    logic [CAP_W-1:0]    rem_s_next;
    logic [CNT_W-1:0]    div_cnt_reg;
    logic [CAP_W:0]      th;
    logic [CAP_W:0]      ts;

    // probing
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] stride_reg;
    logic [CAP_W-1:0] j_reg;
    logic [CAP_W:0]   sum;
    logic [IDX_W-1:0] next_idx;
    logic             hit_empty;
    logic             hit_eq;
    logic             exhausted;
    logic             load_full;
    logic             cmd_known;

    // result
    status_t          res_status_reg;
    status_t          res_status_next;
    logic [IDX_W-1:0] res_slot_reg;
    logic [IDX_W-1:0] res_slot_next;
    rsp_t             rsp_reg;

    // memory port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [RAM_W-1:0] ram_rdata;

    always_comb
    begin
        if (cap_cfg_reg < CAP_CFG_W'(2))
        begin
            cap_eff = CAP_W'(2);
        end
        else if (32'(cap_cfg_reg) > 32'(SLOTS))
        begin
            cap_eff = CAP_W'(SLOTS);
        end
        else
        begin
            cap_eff = CAP_W'(cap_cfg_reg);
        end
    end

    // remainder by capacity, one digit per cycle
    always_comb
    begin
        rem_h_next = rem_h_reg;
        rem_s_next = rem_s_reg;
        th         = '0;
        ts         = '0;
        for (int k = 0; k < DIGIT_W; k++)
        begin
            th = {rem_h_next, h_sh_reg[HASH_W-1-k]};
            if (th >= {1'b0, cap_eff})
            begin
                th = th - {1'b0, cap_eff};
            end
            rem_h_next = th[CAP_W-1:0];
            ts = {rem_s_next, s_sh_reg[HASH_W-1-k]};
            if (ts >= {1'b0, cap_eff})
            begin
                ts = ts - {1'b0, cap_eff};
            end
            rem_s_next = ts[CAP_W-1:0];
        end
    end

    always_comb
    begin
        sum = (CAP_W+1)'(idx_reg) + (CAP_W+1)'(stride_reg);
        if (sum >= {1'b0, cap_eff})
        begin
            sum = sum - {1'b0, cap_eff};
        end
        next_idx = IDX_W'(sum);
    end

    assign ram_raddr = ctl.probe_first ? IDX_W'(rem_h_reg) : next_idx;
    assign hit_empty = !ram_rdata[KEY_BITS];
    assign hit_eq    = ram_rdata[KEY_BITS] && (ram_rdata[KEY_BITS-1:0] == key_reg);
    assign exhausted = (j_reg == (cap_eff - CAP_W'(1)));
    assign load_full = (PROD_W'(count_reg) * PROD_W'(PERCENT))
                       >= (PROD_W'(limit_reg) * PROD_W'(cap_eff));
    assign cmd_known = cmd_reg inside {CMD_INSERT, CMD_SEARCH, CMD_DELETE};

    assign sts.clear_done = (clr_reg == IDX_W'(SLOTS - 1));
    assign sts.div_last   = (div_cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign sts.early_end  = !cmd_known || ((cmd_reg == CMD_INSERT) && load_full);
    assign sts.probe_end  = hit_empty || hit_eq || exhausted;
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        count_next      = count_reg;
        res_status_next = ST_NOT_FOUND;
        res_slot_next   = '0;
        if (ctl.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
        end
        else if (ctl.early_result)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                res_status_next = ST_FULL;
            end
        end
        else if (ctl.commit)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    if (hit_empty)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = {1'b1, key_reg};
                        count_next      = count_reg + CAP_W'(1);
                        res_status_next = ST_NEW;
                        res_slot_next   = idx_reg;
                    end
                    else if (hit_eq)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = {1'b1, key_reg};
                        res_status_next = ST_REPLACED;
                        res_slot_next   = idx_reg;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                end
                CMD_SEARCH:
                begin
                    if (hit_eq)
                    begin
                        res_status_next = ST_FOUND;
                        res_slot_next   = idx_reg;
                    end
                end
                CMD_DELETE:
                begin
                    if (hit_eq)
                    begin
                        ram_we          = 1'b1;
                        res_status_next = ST_DELETED;
                        res_slot_next   = idx_reg;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CAP_W'(1);
                        end
                    end
                end
                default:
                begin
                    res_status_next = ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg   <= CAP_RESET;
            limit_reg     <= LIMIT_RESET;
            clr_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CAPACITY:   cap_cfg_reg <= cfg_data;
                    REG_LOAD_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                    default:        limit_reg   <= limit_reg;
                endcase
            end
            if (ctl.clear_step)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            count_reg <= count_next;
            if (ctl.load_item)
            begin
                div_cnt_reg <= '0;
            end
            else if (ctl.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + CNT_W'(1);
            end
            if (ctl.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg   <= req.cmd;
            key_reg   <= KEY_BITS'(req.key);
            h_sh_reg  <= req.primary_hash;
            s_sh_reg  <= req.step_hash;
            rem_h_reg <= '0;
            rem_s_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            h_sh_reg  <= h_sh_reg << DIGIT_W;
            s_sh_reg  <= s_sh_reg << DIGIT_W;
            rem_h_reg <= rem_h_next;
            rem_s_reg <= rem_s_next;
        end
        if (ctl.probe_first)
        begin
            idx_reg    <= IDX_W'(rem_h_reg);
            stride_reg <= IDX_W'(rem_s_reg);
            j_reg      <= '0;
        end
        else if (ctl.probe_next)
        begin
            idx_reg <= next_idx;
            j_reg   <= j_reg + CAP_W'(1);
        end
        if (ctl.commit || ctl.early_result)
        begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
        end
        if (ctl.emit)
        begin
            rsp_reg.status        <= res_status_reg;
            rsp_reg.slot          <= SLOT_W'(res_slot_reg);
            rsp_reg.element_total <= TOTAL_W'(count_reg);
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    dht_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/dht_chk.sv =====
`include "assert_macros.svh"

module dht_chk #(
    parameter int SLOTS = dht_pkg::SLOTS_DEFAULT
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input dht_pkg::rsp_t rsp
);

    import dht_pkg::*;

    // stalled result word holds
    `DHT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp changed while stalled")

    // one item in flight: no accept right after an accept
    `DHT_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready, "req accepted back to back")

    // misses and refusals report slot zero
    `DHT_ASSERT_NEVER(a_slot_zero, rsp_valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL) && rsp.slot != '0, "nonzero slot on miss")

    // occupancy never exceeds the table
    `DHT_ASSERT_NEVER(a_total_bound, rsp_valid && (32'(rsp.element_total) > 32'(SLOTS)), "element_total above table size")

endmodule

bind double_hash_table_engine dht_chk #(.SLOTS(SLOTS)) u_dht_chk (.*);
